>>> rtl/cfsc_pkg.sv
// Package for the command frame sum check parser.
// Holds frame byte codes, the parse position and outcome types, and shared structs.
// No dependencies.
package cfsc_pkg;

	localparam int unsigned ByteW = 8;

	localparam logic [ByteW-1:0] HEAD_BYTE    = 8'hBB;
	localparam logic [ByteW-1:0] ADDR_BYTE    = 8'h10;
	localparam logic [ByteW-1:0] FIXED_BYTE   = 8'hF1;
	localparam logic [ByteW-1:0] END_BYTE     = 8'hEE;
	localparam logic [ByteW-1:0] FUNC_MISSION = 8'h10;
	localparam logic [ByteW-1:0] FUNC_TARGET  = 8'h20;
	localparam logic [ByteW-1:0] MISSION_MAX  = 8'd4;

	localparam logic [ByteW-1:0] TARGET_A_RST = 8'd202;
	localparam logic [ByteW-1:0] TARGET_B_RST = 8'd203;
	localparam logic [ByteW-1:0] TARGET_C_RST = 8'd204;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_TARGET_A = 2'd0,
		CFG_TARGET_B = 2'd1,
		CFG_TARGET_C = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_index_t;

	// position within the eight-byte frame
	typedef enum logic [2:0] {
		POS_HEAD  = 3'd0,
		POS_ADDR  = 3'd1,
		POS_FIXED = 3'd2,
		POS_FUNC  = 3'd3,
		POS_MSG   = 3'd4,
		POS_END   = 3'd5,
		POS_SC    = 3'd6,
		POS_AC    = 3'd7
	} frame_pos_t;

	typedef enum logic [1:0] {
		OUT_MISSION    = 2'd0,
		OUT_TARGET     = 2'd1,
		OUT_REJECTED   = 2'd2,
		OUT_CHECK_FAIL = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [ByteW-1:0] code_a;
		logic [ByteW-1:0] code_b;
		logic [ByteW-1:0] code_c;
	} target_codes_t;

	typedef struct packed {
		logic             vld;
		outcome_t         outcome;
		logic [ByteW-1:0] value;
	} frame_res_t;

endpackage

>>> rtl/command_frame_sum_check_parser_top.sv
// Top level of the command frame sum check parser.
// Depends on cfsc_pkg, cfsc_cfg_regs and cfsc_frame_fsm.
//
// Usage:
//   Input channel (in_valid/in_ready/rx_byte) carries one received word per
//   handshake. Frames are eight words: head BB, address 10, fixed F1,
//   function, message, end EE, sum check, add check. A wrong head is
//   skipped; a wrong address, fixed or end word drops the frame without
//   re-testing that word as a head.
//   Output channel (out_valid/out_ready/outcome/value) carries one word per
//   completed frame: mission number, chosen target code, content rejected
//   or checksum failed. Other words give no output.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   the three accepted target codes; cfg_ready is always high. Write only
//   while no frame word is in flight.
//   Throughput: one word per cycle unless a held result stalls the parse
//   step, a combinational step between the input and result registers.
//   Result path: the add check word is taken into the input register,
//   parsed out of it, and its result word is held in the result register.
//   Reset: parser waits for a head, sums clear, target codes return to
//   CA, CB, CC, no output is pending.
//   Stall: a held result blocks the parse stage; the input register still
//   takes one more word, then in_ready drops until out_ready frees it.
module command_frame_sum_check_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] outcome,
	output logic [7:0] value,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import cfsc_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          advance;
	logic          step;
	target_codes_t codes;
	frame_res_t    res;
	logic          out_valid_q;
	outcome_t      outcome_q;
	logic [7:0]    value_q;

	// advance the parse stage whenever the result register is free or draining
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	cfsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.codes     (codes)
	);

	cfsc_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.codes   (codes),
		.res     (res)
	);

	// result register: load on advance, hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.vld) begin
			outcome_q <= res.outcome;
			value_q   <= res.value;
		end
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign value     = value_q;

`ifndef SYNTH
	a_no_step_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !step)
		else $error("parse stage advanced into a stalled result");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |=> out_valid_q)
		else $error("frame result lost");

	a_stage_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !in_ready)
		else $error("input word overwrote a held word");
`endif

endmodule

>>> rtl/cfsc_cfg_regs.sv
// Target code configuration registers of the command frame parser.
// Depends on cfsc_pkg.
module cfsc_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	output cfsc_pkg::target_codes_t codes
);
	import cfsc_pkg::*;

	target_codes_t codes_q;

	assign cfg_ready = 1'b1;
	assign codes     = codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.code_a <= TARGET_A_RST;
			codes_q.code_b <= TARGET_B_RST;
			codes_q.code_c <= TARGET_C_RST;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_TARGET_A: codes_q.code_a <= cfg_data;
				CFG_TARGET_B: codes_q.code_b <= cfg_data;
				CFG_TARGET_C: codes_q.code_c <= cfg_data;
				default: begin
					// drop writes to unused indexes
				end
			endcase
		end
	end

endmodule

>>> rtl/cfsc_frame_fsm.sv
// Frame position tracker, checksum accumulators and result decode.
// Depends on cfsc_pkg.
module cfsc_frame_fsm (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              rx_byte,
	input  cfsc_pkg::target_codes_t codes,
	output cfsc_pkg::frame_res_t    res
);
	import cfsc_pkg::*;

	frame_pos_t  pos_q, pos_d;
	logic [7:0]  func_q, msg_q;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  sos_q, sos_d;
	logic        sum_ok_q, sum_ok_d;
	logic [7:0]  acc_sum;
	logic [7:0]  acc_sos;
	logic [7:0]  head_sos;

	// running sums with this word folded in
	assign acc_sum  = sum_q + rx_byte;
	assign acc_sos  = sos_q + acc_sum;
	assign head_sos = rx_byte;

	// next state
	always_comb begin
		pos_d    = pos_q;
		sum_d    = sum_q;
		sos_d    = sos_q;
		sum_ok_d = sum_ok_q;
		case (pos_q)
			POS_HEAD: begin
				if (rx_byte == HEAD_BYTE) begin
					sum_d    = rx_byte;
					sos_d    = head_sos;
					sum_ok_d = 1'b0;
					pos_d    = POS_ADDR;
				end
			end
			POS_ADDR: begin
				if (rx_byte == ADDR_BYTE) begin
					sum_d = acc_sum;
					sos_d = acc_sos;
					pos_d = POS_FIXED;
				end else begin
					pos_d = POS_HEAD;
				end
			end
			POS_FIXED: begin
				if (rx_byte == FIXED_BYTE) begin
					sum_d = acc_sum;
					sos_d = acc_sos;
					pos_d = POS_FUNC;
				end else begin
					pos_d = POS_HEAD;
				end
			end
			POS_FUNC: begin
				sum_d = acc_sum;
				sos_d = acc_sos;
				pos_d = POS_MSG;
			end
			POS_MSG: begin
				sum_d = acc_sum;
				sos_d = acc_sos;
				pos_d = POS_END;
			end
			POS_END: begin
				if (rx_byte == END_BYTE) begin
					sum_d = acc_sum;
					sos_d = acc_sos;
					pos_d = POS_SC;
				end else begin
					pos_d = POS_HEAD;
				end
			end
			POS_SC: begin
				sum_ok_d = (rx_byte == sum_q);
				pos_d    = POS_AC;
			end
			POS_AC: begin
				sum_ok_d = 1'b0;
				pos_d    = POS_HEAD;
			end
			default: pos_d = POS_HEAD;
		endcase
	end

	// result decode on the add check word
	always_comb begin
		res.vld     = step && (pos_q == POS_AC);
		res.outcome = OUT_REJECTED;
		res.value   = '0;
		if (!(sum_ok_q && (rx_byte == sos_q))) begin
			res.outcome = OUT_CHECK_FAIL;
		end else if ((func_q == FUNC_MISSION) && (msg_q <= MISSION_MAX)) begin
			res.outcome = OUT_MISSION;
			res.value   = msg_q;
		end else if ((func_q == FUNC_TARGET) &&
				((msg_q == codes.code_a) || (msg_q == codes.code_b) ||
				 (msg_q == codes.code_c))) begin
			res.outcome = OUT_TARGET;
			res.value   = msg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HEAD;
			sum_q    <= '0;
			sos_q    <= '0;
			sum_ok_q <= 1'b0;
		end else if (step) begin
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			sos_q    <= sos_d;
			sum_ok_q <= sum_ok_d;
		end
	end

	// function and message bytes are always captured before they are read
	always_ff @(posedge clk) begin
		if (step && (pos_q == POS_FUNC)) begin
			func_q <= rx_byte;
		end
		if (step && (pos_q == POS_MSG)) begin
			msg_q <= rx_byte;
		end
	end

`ifndef SYNTH
	a_ac_returns_head: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (pos_q == POS_AC)) |=> (pos_q == POS_HEAD))
		else $error("parser did not return to head after add check");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(pos_q) && $stable(sum_q) && $stable(sos_q)))
		else $error("parse state moved without a word");

	a_mission_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && (res.outcome == OUT_MISSION)) |-> (res.value <= MISSION_MAX))
		else $error("mission number out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && ((res.outcome == OUT_REJECTED) ||
		 (res.outcome == OUT_CHECK_FAIL))) |-> (res.value == '0))
		else $error("non-zero value on rejected frame");
`endif

endmodule

>>> test/tb_command_frame_sum_check_parser_top.sv
// Testbench for command_frame_sum_check_parser_top: feeds received words and frames,
// predicts the frame outcomes, and checks every result word against that prediction.
// Depends on cfsc_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_command_frame_sum_check_parser_top;

	import cfsc_pkg::*;

	localparam int unsigned CLK_PERIOD     = 12;
	localparam int unsigned LAT_CYCLES     = 1;    // add check word to result word
	localparam int unsigned QUIET_CYCLES   = LAT_CYCLES + 2;
	localparam int unsigned EXP_DEPTH      = 64;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	typedef enum logic [1:0] {
		ITEM_WORD,
		ITEM_CFG,
		ITEM_DRAIN
	} item_kind_t;

	// one entry of the sender's to-do list
	typedef struct {
		item_kind_t kind;
		logic [7:0] data;
		cfg_index_t idx;
	} stim_item_t;

	typedef struct packed {
		outcome_t   kind;
		logic [7:0] val;
	} frame_expect_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] outcome;
	logic [7:0] value;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_TARGET_A;
	logic [7:0] cfg_data  = 8'h00;

	// words waiting to be sent, filled once at time zero
	stim_item_t stim_q[$];

	// expected frame outcomes, a ring written by the sender and read by the checker
	frame_expect_t frame_exp [0:EXP_DEPTH-1];
	logic [15:0]   exp_wr_ptr = 16'd0;
	logic [15:0]   exp_rd_ptr = 16'd0;

	// parser model state
	frame_pos_t    parse_pos;
	logic [7:0]    fn_byte;
	logic [7:0]    msg_byte;
	logic [7:0]    sum_sc;
	logic [7:0]    sum_ac;
	logic          sc_ok;
	target_codes_t model_codes;

	// generator's view of the codes it has asked for
	target_codes_t plan_codes;
	int unsigned   words_queued;

	int unsigned err_count  = 0;
	int unsigned idle_count = 0;

	command_frame_sum_check_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.outcome   (outcome),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: ERROR %s", $time, msg);
		err_count++;
	endtask

	// ------------------------------------------------------------------
	// Frame model
	// ------------------------------------------------------------------

	task automatic add_to_sums(input logic [7:0] b);
		sum_sc = sum_sc + b;
		sum_ac = sum_ac + sum_sc;
	endtask

	// Advance the model by one accepted word; push the outcome when the
	// add check word closes a frame.
	task automatic parse_word(input logic [7:0] b);
		logic          done;
		frame_expect_t res;
		done     = 1'b0;
		res.kind = OUT_REJECTED;
		res.val  = 8'h00;
		case (parse_pos)
			POS_HEAD: begin
				// anything but a head is skipped here
				if (b == HEAD_BYTE) begin
					sum_sc = 8'h00;
					sum_ac = 8'h00;
					sc_ok  = 1'b0;
					add_to_sums(b);
					parse_pos = POS_ADDR;
				end
			end
			POS_ADDR: begin
				if (b == ADDR_BYTE) begin
					add_to_sums(b);
					parse_pos = POS_FIXED;
				end else begin
					parse_pos = POS_HEAD;
				end
			end
			POS_FIXED: begin
				if (b == FIXED_BYTE) begin
					add_to_sums(b);
					parse_pos = POS_FUNC;
				end else begin
					parse_pos = POS_HEAD;
				end
			end
			POS_FUNC: begin
				fn_byte = b;
				add_to_sums(b);
				parse_pos = POS_MSG;
			end
			POS_MSG: begin
				msg_byte = b;
				add_to_sums(b);
				parse_pos = POS_END;
			end
			POS_END: begin
				if (b == END_BYTE) begin
					add_to_sums(b);
					parse_pos = POS_SC;
				end else begin
					parse_pos = POS_HEAD;
				end
			end
			POS_SC: begin
				sc_ok     = (b == sum_sc);
				parse_pos = POS_AC;
			end
			default: begin
				parse_pos = POS_HEAD;
				done      = 1'b1;
				if (!(sc_ok && b == sum_ac)) begin
					res.kind = OUT_CHECK_FAIL;
				end else if (fn_byte == FUNC_MISSION && msg_byte <= MISSION_MAX) begin
					res.kind = OUT_MISSION;
					res.val  = msg_byte;
				end else if (fn_byte == FUNC_TARGET && (msg_byte == model_codes.code_a ||
						msg_byte == model_codes.code_b || msg_byte == model_codes.code_c)) begin
					res.kind = OUT_TARGET;
					res.val  = msg_byte;
				end
				sc_ok = 1'b0;
			end
		endcase
		if (done) begin
			frame_exp[exp_wr_ptr[5:0]] <= res;
			exp_wr_ptr <= exp_wr_ptr + 16'd1;
		end
	endtask

	task automatic write_code(input logic [1:0] idx, input logic [7:0] data);
		case (cfg_index_t'(idx))
			CFG_TARGET_A: model_codes.code_a = data;
			CFG_TARGET_B: model_codes.code_b = data;
			CFG_TARGET_C: model_codes.code_c = data;
			default: ;   // unused index is dropped
		endcase
	endtask

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	task automatic queue_word(input logic [7:0] b);
		stim_item_t it;
		it.kind = ITEM_WORD;
		it.data = b;
		it.idx  = CFG_TARGET_A;
		stim_q.push_back(it);
		words_queued++;
	endtask

	task automatic queue_cfg(input cfg_index_t idx, input logic [7:0] data);
		stim_item_t it;
		it.kind = ITEM_CFG;
		it.data = data;
		it.idx  = idx;
		stim_q.push_back(it);
		case (idx)
			CFG_TARGET_A: plan_codes.code_a = data;
			CFG_TARGET_B: plan_codes.code_b = data;
			CFG_TARGET_C: plan_codes.code_c = data;
			default: ;
		endcase
	endtask

	// hold the sender until every outstanding result has come back
	task automatic queue_drain();
		stim_item_t it;
		it.kind = ITEM_DRAIN;
		it.data = 8'h00;
		it.idx  = CFG_TARGET_A;
		stim_q.push_back(it);
	endtask

	task automatic queue_frame(input logic [7:0] fn, input logic [7:0] msg,
			input bit bad_sc, input bit bad_ac);
		logic [7:0] body [6];
		logic [7:0] sc;
		logic [7:0] ac;
		body = '{HEAD_BYTE, ADDR_BYTE, FIXED_BYTE, fn, msg, END_BYTE};
		sc   = 8'h00;
		ac   = 8'h00;
		foreach (body[i]) begin
			queue_word(body[i]);
			sc = sc + body[i];
			ac = ac + sc;
		end
		if (bad_sc)
			sc = sc ^ 8'($urandom_range(1, 255));
		if (bad_ac)
			ac = ac ^ 8'($urandom_range(1, 255));
		queue_word(sc);
		queue_word(ac);
	endtask

	// frame cut short by a wrong address, fixed or end word; often the
	// wrong word is a head, which must not restart the frame
	task automatic queue_broken();
		int unsigned cut;
		logic [7:0]  bad;
		cut = $urandom_range(0, 2);
		bad = ($urandom_range(0, 3) == 0) ? HEAD_BYTE : 8'($urandom);
		queue_word(HEAD_BYTE);
		case (cut)
			0: begin
				if (bad == ADDR_BYTE)
					bad = ~bad;
				queue_word(bad);
			end
			1: begin
				queue_word(ADDR_BYTE);
				if (bad == FIXED_BYTE)
					bad = ~bad;
				queue_word(bad);
			end
			default: begin
				queue_word(ADDR_BYTE);
				queue_word(FIXED_BYTE);
				queue_word(8'($urandom));
				queue_word(8'($urandom));
				if (bad == END_BYTE)
					bad = ~bad;
				queue_word(bad);
			end
		endcase
	endtask

	task automatic queue_random_frame(input bit bad_sum);
		int unsigned r;
		logic [7:0]  fn;
		logic [7:0]  msg;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			fn  = FUNC_MISSION;
			msg = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
		end else if (r < 90) begin
			fn = FUNC_TARGET;
			case ($urandom_range(0, 4))
				0: msg = plan_codes.code_a;
				1: msg = plan_codes.code_b;
				2: msg = plan_codes.code_c;
				default: msg = 8'($urandom);
			endcase
		end else begin
			fn  = 8'($urandom);
			msg = 8'($urandom);
		end
		// spoil the sum check, the add check or both
		r = $urandom_range(1, 3);
		if (bad_sum)
			queue_frame(fn, msg, r[0], r[1]);
		else
			queue_frame(fn, msg, 1'b0, 1'b0);
	endtask

	// mostly well-formed frames; the rest checksum errors, cut frames and noise
	task automatic queue_traffic(input int unsigned n_words);
		int unsigned stop_at;
		int unsigned r;
		stop_at = words_queued + n_words;
		while (words_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_random_frame(1'b0);
			end else if (r < 80) begin
				queue_random_frame(1'b1);
			end else if (r < 90) begin
				queue_broken();
			end else begin
				repeat ($urandom_range(1, 4))
					queue_word(8'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : feed_proc
		logic        nxt_in_valid;
		logic [7:0]  nxt_byte;
		logic        nxt_cfg_valid;
		logic [1:0]  nxt_idx;
		logic [7:0]  nxt_data;
		int unsigned burst_left;
		int unsigned gap_left;
		int unsigned quiet;
		if (!arst_n) begin
			in_valid    <= 1'b0;
			rx_byte     <= 8'h00;
			cfg_valid   <= 1'b0;
			cfg_index   <= CFG_TARGET_A;
			cfg_data    <= 8'h00;
			exp_wr_ptr  <= 16'd0;
			burst_left  = 0;
			gap_left    = 0;
			quiet       = 0;
			parse_pos   = POS_HEAD;
			fn_byte     = 8'h00;
			msg_byte    = 8'h00;
			sum_sc      = 8'h00;
			sum_ac      = 8'h00;
			sc_ok       = 1'b0;
			model_codes = '{TARGET_A_RST, TARGET_B_RST, TARGET_C_RST};
		end else begin
			nxt_in_valid  = in_valid;
			nxt_byte      = rx_byte;
			nxt_cfg_valid = cfg_valid;
			nxt_idx       = cfg_index;
			nxt_data      = cfg_data;

			if (in_valid && in_ready) begin
				parse_word(rx_byte);
				nxt_in_valid = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				write_code(cfg_index, cfg_data);
				nxt_cfg_valid = 1'b0;
			end

			// count cycles with nothing in flight; a word that yields no result
			// may still sit inside the block, so give it the latency to settle
			if (in_valid || cfg_valid || exp_wr_ptr != exp_rd_ptr)
				quiet = 0;
			else
				quiet++;

			if (!nxt_in_valid && !nxt_cfg_valid && stim_q.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					case (stim_q[0].kind)
						ITEM_WORD: begin
							nxt_in_valid = 1'b1;
							nxt_byte     = stim_q[0].data;
							void'(stim_q.pop_front());
							if (burst_left != 0)
								burst_left--;
							if (burst_left == 0) begin
								burst_left = ($urandom_range(0, 7) == 0) ?
									$urandom_range(40, 80) : $urandom_range(1, 12);
								gap_left   = ($urandom_range(0, 3) == 0) ?
									0 : $urandom_range(1, 10);
							end
						end
						ITEM_CFG: begin
							if (quiet >= QUIET_CYCLES) begin
								nxt_cfg_valid = 1'b1;
								nxt_idx       = stim_q[0].idx;
								nxt_data      = stim_q[0].data;
								void'(stim_q.pop_front());
							end
						end
						default: begin
							if (quiet >= QUIET_CYCLES)
								void'(stim_q.pop_front());
						end
					endcase
				end
			end

			in_valid  <= nxt_in_valid;
			rx_byte   <= nxt_byte;
			cfg_valid <= nxt_cfg_valid;
			cfg_index <= nxt_idx;
			cfg_data  <= nxt_data;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: switches between free flow, random stalls and stall runs
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : sink_proc
		int unsigned sink_mode;
		int unsigned mode_left;
		int unsigned run_left;
		logic        stalled;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_mode = 0;
			mode_left = 0;
			run_left  = 0;
			stalled   = 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 150);
			end else begin
				mode_left--;
			end
			case (sink_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					if (run_left == 0) begin
						stalled  = !stalled;
						run_left = stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
					end else begin
						run_left--;
					end
					out_ready <= !stalled;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Checker: compare each result word with the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin : check_proc
		frame_expect_t want;
		if (!arst_n) begin
			exp_rd_ptr <= 16'd0;
		end else if (out_valid && out_ready) begin
			if (exp_rd_ptr == exp_wr_ptr) begin
				report_mismatch($sformatf("unexpected result word outcome=%0d value=0x%02h",
					outcome, value));
			end else begin
				want = frame_exp[exp_rd_ptr[5:0]];
				if (outcome !== want.kind)
					report_mismatch($sformatf("outcome %0d, expected %s", outcome,
						want.kind.name()));
				if (value !== want.val)
					report_mismatch($sformatf("value 0x%02h, expected 0x%02h (%s)", value,
						want.val, want.kind.name()));
				exp_rd_ptr <= exp_rd_ptr + 16'd1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no word moves for too long
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_count <= 0;
		end else if (idle_count >= WATCHDOG_LIMIT) begin
			$display("%0t ns: watchdog expired, %0d results outstanding", $time,
				exp_wr_ptr - exp_rd_ptr);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin : stimulus_proc
		int unsigned wait_left;
		logic [7:0]  dup;
		words_queued = 0;
		plan_codes   = '{TARGET_A_RST, TARGET_B_RST, TARGET_C_RST};

		// directed: reset codes in force
		queue_word(8'h00);                      // noise before any head
		queue_word(8'hFF);
		queue_frame(FUNC_MISSION, 8'd0, 1'b0, 1'b0);
		queue_frame(FUNC_MISSION, MISSION_MAX, 1'b0, 1'b0);
		queue_frame(FUNC_MISSION, MISSION_MAX + 8'd1, 1'b0, 1'b0);
		queue_frame(FUNC_MISSION, 8'hFF, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, TARGET_A_RST, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, TARGET_B_RST, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, TARGET_C_RST, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, 8'h00, 1'b0, 1'b0);
		queue_frame(8'h00, TARGET_A_RST, 1'b0, 1'b0);   // unknown function
		queue_frame(8'hFF, 8'd1, 1'b0, 1'b0);
		queue_frame(FUNC_MISSION, 8'd2, 1'b1, 1'b0);    // sum check wrong
		queue_frame(FUNC_MISSION, 8'd2, 1'b0, 1'b1);    // add check wrong
		// a head in the address slot drops the frame and is not taken as a head,
		// so the following address and fixed words are skipped as noise
		queue_word(HEAD_BYTE);
		queue_word(HEAD_BYTE);
		queue_word(ADDR_BYTE);
		queue_word(FIXED_BYTE);
		queue_frame(FUNC_MISSION, 8'd3, 1'b0, 1'b0);
		// bad fixed and bad end words
		queue_word(HEAD_BYTE);
		queue_word(ADDR_BYTE);
		queue_word(8'h00);
		queue_word(HEAD_BYTE);
		queue_word(ADDR_BYTE);
		queue_word(FIXED_BYTE);
		queue_word(FUNC_TARGET);
		queue_word(TARGET_A_RST);
		queue_word(8'hFF);
		queue_frame(FUNC_TARGET, TARGET_A_RST, 1'b0, 1'b0);
		queue_drain();

		// extremes of the codes
		queue_cfg(CFG_TARGET_A, 8'h00);
		queue_cfg(CFG_TARGET_B, 8'hFF);
		queue_cfg(CFG_TARGET_C, 8'($urandom));
		queue_frame(FUNC_TARGET, 8'h00, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, 8'hFF, 1'b0, 1'b0);
		queue_traffic(250);

		// all three codes equal; a write to the unused index must change nothing
		dup = 8'($urandom);
		queue_cfg(CFG_TARGET_A, dup);
		queue_cfg(CFG_TARGET_B, dup);
		queue_cfg(CFG_TARGET_C, dup);
		queue_cfg(CFG_UNUSED, ~dup);
		queue_frame(FUNC_TARGET, dup, 1'b0, 1'b0);
		queue_frame(FUNC_TARGET, ~dup, 1'b0, 1'b0);
		queue_traffic(250);

		queue_cfg(CFG_TARGET_A, 8'hFF);
		queue_cfg(CFG_TARGET_B, 8'h00);
		queue_cfg(CFG_TARGET_C, 8'h00);
		queue_traffic(250);
		queue_drain();

		queue_cfg(CFG_TARGET_A, 8'($urandom));
		queue_cfg(CFG_TARGET_B, 8'($urandom));
		queue_cfg(CFG_TARGET_C, 8'($urandom));
		queue_cfg(CFG_UNUSED, 8'($urandom));
		queue_traffic(250);

		queue_cfg(CFG_TARGET_A, TARGET_A_RST);
		queue_cfg(CFG_TARGET_B, TARGET_B_RST);
		queue_cfg(CFG_TARGET_C, TARGET_C_RST);
		queue_traffic(50);

		// release reset once the stimulus list is built
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// hold until the list is empty and the last word has gone
		while (stim_q.size() != 0 || in_valid || cfg_valid)
			@(negedge clk);
		wait_left = 400;
		while (exp_wr_ptr != exp_rd_ptr && wait_left != 0) begin
			@(negedge clk);
			wait_left--;
		end
		repeat (LAT_CYCLES + 4) @(negedge clk);
		if (exp_wr_ptr != exp_rd_ptr)
			report_mismatch($sformatf("%0d expected results never arrived",
				exp_wr_ptr - exp_rd_ptr));

		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
